/* src/msp_pkg.sv */
// Shared constants and types for the majority stride page prefetcher.
package msp_pkg;

  localparam int unsigned PageW       = 52;
  localparam int unsigned DeltaW      = 53;
  localparam int unsigned HistDepthDf = 8;
  localparam int unsigned WindowCap   = 1 << 3;
  localparam int unsigned CntW        = 4;
  localparam int unsigned HitsMax     = 15;

  typedef logic [PageW-1:0]  page_t;
  typedef logic [DeltaW-1:0] delta_t;

endpackage

/* src/msp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module msp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/majority_stride_page_prefetcher.sv */
// Top level of the majority stride page prefetcher.
// Each item is a page event. A hit item (func_i = 0) is pushed into a ring of
// (page, delta) held in two synchronous RAMs with a registered read and
// produces no result. After a hit item is accepted the input stalls while the
// newest page is read and then the new entry is written, so a new hit item is
// taken only after both steps. A fault item is pushed the same way. A
// Boyer-Moore vote then runs over the newest 2, 4, 8 ... deltas, reading one
// delta per cycle from the delta RAM. Each region has a candidate pass and a
// count pass. With a full history of eight a fault runs up to three regions.
// Up to 8 results follow, one per cycle while the output is not stalled. The
// input stays stalled until the last result of the run is loaded into the
// output register. The stride is the majority delta, else the previous stride,
// else +1/-1 by direction from the previous fault page. The block takes one
// item at a time.
module majority_stride_page_prefetcher #(
  parameter int unsigned HISTORY_DEPTH = msp_pkg::HistDepthDf
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [msp_pkg::PageW-1:0] page_number_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [msp_pkg::PageW-1:0] prefetch_page_o,
  output logic                     from_trend_o,
  output logic                     last_o
);

  import msp_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * HISTORY_DEPTH + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdTop = 4'd1;
  localparam logic [3:0] StPush  = 4'd2;
  localparam logic [3:0] StVoteA = 4'd3;
  localparam logic [3:0] StVoteB = 4'd4;
  localparam logic [3:0] StCntA  = 4'd5;
  localparam logic [3:0] StCntB  = 4'd6;
  localparam logic [3:0] StWin   = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic          func_q;
  page_t         page_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [CntW-1:0] hits_q, lastwin_q;
  page_t         pfault_q;
  delta_t        pstride_q;
  logic [SW-1:0] size_q;
  logic [SW-1:0] j_q;
  logic [SW-1:0] cnt_q;
  delta_t        cand_q, stride_q;
  logic          trend_q;
  logic [CntW-1:0] win_q, k_q;
  page_t         acc_q;

  // RAM ports
  logic          we;
  logic [AW-1:0] raddr;
  page_t         rpage;
  delta_t        rdelta, wdelta;

  msp_ram #(.Width(PageW), .Depth(HISTORY_DEPTH)) u_page_ram (
    .clk_i, .we_i(we), .waddr_i(head_q), .wdata_i(page_q),
    .raddr_i(raddr), .rdata_o(rpage)
  );
  msp_ram #(.Width(DeltaW), .Depth(HISTORY_DEPTH)) u_delta_ram (
    .clk_i, .we_i(we), .waddr_i(head_q), .wdata_i(wdelta),
    .raddr_i(raddr), .rdata_o(rdelta)
  );

  // slot of a given age: head - 1 - age (mod depth), age never above depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd,
                                            input logic [SW-1:0] age);
    logic [SW+AW:0] s;
    begin
      s = (SW+AW+1)'(hd) + (SW+AW+1)'(2 * HISTORY_DEPTH - 1) - (SW+AW+1)'(age);
      if (s >= (SW+AW+1)'(2 * HISTORY_DEPTH)) s = s - (SW+AW+1)'(2 * HISTORY_DEPTH);
      else if (s >= (SW+AW+1)'(HISTORY_DEPTH)) s = s - (SW+AW+1)'(HISTORY_DEPTH);
      return AW'(s);
    end
  endfunction

  assign we = (state_q == StPush);
  assign wdelta = (fill_q == '0) ? '0 : delta_t'({1'b0, page_q} - {1'b0, rpage});

  always_comb begin
    raddr = slot_of(head_q, j_q);
    if (state_q == StIdle || state_q == StRdTop) raddr = slot_of(head_q, '0);
  end

  // window choice
  logic [CntW-1:0] pages, half, win_n;
  always_comb begin
    priority case (1'b1)
      (hits_q == '0): pages = trend_q ? CntW'(1) : CntW'(0);
      (hits_q == CntW'(1)): pages = CntW'(2);
      (hits_q <= CntW'(3)): pages = CntW'(4);
      default: pages = CntW'(WindowCap);
    endcase
    half  = lastwin_q >> 1;
    win_n = (pages < half) ? half : pages;
  end

  // region control: after the push start with two, after a failed count double
  logic [SW-1:0] nsz;
  logic [FW-1:0] fill_cmp;
  logic          found, fits;
  always_comb begin
    nsz      = (state_q == StPush) ? SW'(WindowCap / 4) : SW'(size_q << 1);
    fill_cmp = (state_q == StPush && fill_q < FW'(HISTORY_DEPTH)) ? fill_q + 1'b1 : fill_q;
    fits     = (nsz <= SW'(fill_cmp));
    found    = ((cnt_q + SW'(rdelta == cand_q)) > (size_q >> 1));
  end

  assign in_stall_o = (state_q != StIdle);

  logic emit_fire;
  assign emit_fire = (state_q == StEmit) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StRdTop;
      StRdTop: state_d = StPush;
      StPush:  state_d = !func_q ? StIdle : (fits ? StVoteA : StWin);
      StVoteA: state_d = StVoteB;
      StVoteB: state_d = (j_q == size_q) ? StCntA : StVoteB;
      StCntA:  state_d = StCntB;
      StCntB:  if (j_q == size_q) state_d = (!found && fits) ? StVoteA : StWin;
      StWin:   state_d = (win_n == '0) ? StIdle : StEmit;
      StEmit:  if (emit_fire && k_q == win_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit_fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      prefetch_page_o <= acc_q + stride_q[PageW-1:0];
      from_trend_o    <= trend_q;
      last_o          <= (k_q == win_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      func_q    <= 1'b0;
      page_q    <= '0;
      head_q    <= '0;
      fill_q    <= '0;
      hits_q    <= '0;
      lastwin_q <= '0;
      pfault_q  <= '0;
      pstride_q <= '0;
      trend_q   <= 1'b0;
      size_q    <= '0;
      j_q       <= '0;
      cnt_q     <= '0;
      cand_q    <= '0;
      stride_q  <= '0;
      acc_q     <= '0;
      k_q       <= '0;
      win_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          func_q <= func_i;
          page_q <= page_number_i;
        end
        StRdTop: ;
        StPush: begin
          head_q <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
          if (fill_q < FW'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
          if (!func_q) begin
            if (hits_q < CntW'(HitsMax)) hits_q <= hits_q + 1'b1;
          end
          trend_q <= 1'b0;
          size_q  <= nsz;
          j_q     <= '0;
        end
        StVoteA: begin
          // delta of age 0 arrives next cycle; candidate starts there
          j_q <= j_q + 1'b1;
        end
        StVoteB: begin
          // rdelta holds the delta of age j_q - 1
          if (j_q == SW'(1)) begin
            cand_q <= rdelta;
            cnt_q  <= SW'(1);
          end else if (rdelta == cand_q) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (cnt_q == SW'(1)) begin
            cand_q <= rdelta;
            cnt_q  <= SW'(1);
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
          j_q <= (j_q == size_q) ? '0 : j_q + 1'b1;
        end
        StCntA: begin
          cnt_q <= '0;
          j_q   <= j_q + 1'b1;
        end
        StCntB: begin
          if (j_q == size_q) begin
            if (found) begin
              trend_q <= 1'b1;
            end else begin
              size_q <= nsz;
              j_q    <= '0;
            end
          end else begin
            if (rdelta == cand_q) cnt_q <= cnt_q + 1'b1;
            j_q <= j_q + 1'b1;
          end
        end
        StWin: begin
          win_q     <= win_n;
          lastwin_q <= win_n;
          k_q       <= CntW'(1);
          acc_q     <= page_q;
          if (!trend_q) begin
            if (pstride_q == '0) stride_q <= (page_q > pfault_q) ? DeltaW'(1) : '1;
            else stride_q <= pstride_q;
          end else begin
            stride_q <= cand_q;
          end
          pfault_q <= page_q;
          hits_q   <= '0;
        end
        StEmit: if (emit_fire) begin
          acc_q     <= acc_q + stride_q[PageW-1:0];
          k_q       <= k_q + 1'b1;
          pstride_q <= stride_q;
        end
        default: ;
      endcase
    end
  end

  // vote region never exceeds the filled history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StVoteB) |-> ({1'b0, size_q} <= (SW+1)'(fill_q)))
    else $error("vote region larger than history");
  // results never go beyond a non-empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (k_q <= win_q && win_q != '0))
    else $error("prefetch beyond window");
  // input is held off while results are emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> in_stall_o)
    else $error("input accepted while emitting");

endmodule
